/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the task dispatcher RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_IMPLY(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while the active-low reset is asserted.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ptd_pkg.sv */
// ----------------------------------------------------------------------------
// ptd_pkg
// Types, constants and controller/datapath interface structs for the
// priority task dispatcher.
// ----------------------------------------------------------------------------
package ptd_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned CntW       = IdxW + 1;
  localparam int unsigned PrioW      = 8;
  localparam int unsigned ReqPrioW   = 8;
  localparam int unsigned LimitW     = 7;
  localparam int unsigned CompW      = 32;

  localparam logic [LimitW-1:0] DefaultLimit = LimitW'(4);

  typedef enum logic [1:0] {
    OpSubmit   = 2'd0,
    OpDispatch = 2'd1,
    OpComplete = 2'd2,
    OpNop      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ResOk      = 3'd0,
    ResFull    = 3'd1,
    ResLimit   = 3'd2,
    ResNone    = 3'd3,
    ResBadSlot = 3'd4
  } res_e;

  typedef enum logic [1:0] {
    TsQueued  = 2'd0,
    TsRunning = 2'd1,
    TsDone    = 2'd2,
    TsFailed  = 2'd3
  } tstat_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture the request fields
    logic rd_req;      // read the table at the requested slot
    logic scan_clear;  // restart the scan address
    logic scan_issue;  // read the table at the scan address and advance
    logic commit;      // apply the operation and load the result register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic limit_hit;
    logic table_empty;
    logic scan_last;
    logic out_free;
  } sts_t;

endpackage

/* rtl/ptd_ctrl.sv */
// ----------------------------------------------------------------------------
// ptd_ctrl
// Sequencing state machine: accepts a request, runs the table read or the
// dispatch scan, and commits once the result register can take the result.
// ----------------------------------------------------------------------------
module ptd_ctrl import ptd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  op_e  op_i,
  input  sts_t sts_i,
  output logic in_ready_o,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    SIdle  = 5'b00001,
    SRead  = 5'b00010,
    SScan  = 5'b00100,
    SDrain = 5'b01000,
    SExec  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (op_i)
            OpComplete: state_d = SRead;
            OpDispatch: begin
              if (!sts_i.limit_hit && !sts_i.table_empty) begin
                cmd_o.scan_clear = 1'b1;
                state_d          = SScan;
              end else begin
                state_d = SExec;
              end
            end
            default: state_d = SExec;
          endcase
        end
      end
      SRead: begin
        cmd_o.rd_req = 1'b1;
        state_d      = SExec;
      end
      SScan: begin
        cmd_o.scan_issue = 1'b1;
        if (sts_i.scan_last) begin
          state_d = SDrain;
        end
      end
      SDrain: begin
        // The last scan read returns and is compared in this cycle.
        state_d = SExec;
      end
      SExec: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/ptd_datapath.sv */
// ----------------------------------------------------------------------------
// ptd_datapath
// Task table memories, request registers, scan comparator, counters and the
// result register.
// ----------------------------------------------------------------------------
module ptd_datapath import ptd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  cmd_t                       cmd_i,
  output sts_t                       sts_o,
  input  logic [LimitW-1:0]          limit_i,
  input  op_e                        op_i,
  input  logic signed [ReqPrioW-1:0] priority_req_i,
  input  logic [IdxW-1:0]            task_index_i,
  input  logic                       success_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output res_e                       status_o,
  output logic [IdxW-1:0]            slot_o,
  output logic [CntW-1:0]            queued_count_o,
  output logic [CntW-1:0]            running_count_o,
  output logic [CompW-1:0]           completed_count_o
);

  // Task table, one write port and one registered read port.
  logic signed [PrioW-1:0] prio_mem [TableDepth];
  tstat_e                  stat_mem [TableDepth];

  // Request registers.
  op_e                     op_q;
  logic signed [PrioW-1:0] prio_q;
  logic [IdxW-1:0]         idx_q;
  logic                    success_q;

  // Table read data and scan pipeline.
  logic signed [PrioW-1:0] prio_rd_q;
  tstat_e                  stat_rd_q;
  logic                    scan_vld_q;
  logic [IdxW-1:0]         scan_idx_q;
  logic [CntW-1:0]         scan_addr_q;
  logic                    found_q, found_d;
  logic signed [PrioW-1:0] best_prio_q, best_prio_d;
  logic [IdxW-1:0]         best_idx_q, best_idx_d;

  // Architectural counters.
  logic [CntW-1:0]  task_count_q, task_count_d;
  logic [CntW-1:0]  queued_q, queued_d;
  logic [CntW-1:0]  running_q, running_d;
  logic [CompW-1:0] completed_q, completed_d;

  // Result register.
  logic            out_valid_q;
  res_e            res_q, res_d;
  logic [IdxW-1:0] slot_q, slot_d;

  // Table writes and reads.
  logic            prio_we, stat_we;
  tstat_e          stat_wdata;
  logic [IdxW-1:0] wr_addr;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;

  logic [LimitW-1:0] limit_eff;
  logic              limit_hit;
  logic              take;

  assign limit_eff = (limit_i == '0) ? DefaultLimit : limit_i;
  assign limit_hit = running_q >= limit_eff;

  assign sts_o.limit_hit   = limit_hit;
  assign sts_o.table_empty = (task_count_q == '0);
  assign sts_o.scan_last   = (scan_addr_q == task_count_q - CntW'(1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign rd_en   = cmd_i.rd_req || cmd_i.scan_issue;
  assign rd_addr = cmd_i.scan_issue ? scan_addr_q[IdxW-1:0] : idx_q;

  // Scan comparator: strictly greater keeps the lowest slot on ties.
  assign take = scan_vld_q && (stat_rd_q == TsQueued)
                && (!found_q || (prio_rd_q > best_prio_q));

  always_comb begin
    found_d     = found_q;
    best_prio_d = best_prio_q;
    best_idx_d  = best_idx_q;
    if (cmd_i.load) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d     = 1'b1;
      best_prio_d = prio_rd_q;
      best_idx_d  = scan_idx_q;
    end
  end

  always_comb begin
    task_count_d = task_count_q;
    queued_d     = queued_q;
    running_d    = running_q;
    completed_d  = completed_q;
    res_d        = ResOk;
    slot_d       = '0;
    prio_we      = 1'b0;
    stat_we      = 1'b0;
    stat_wdata   = TsQueued;
    wr_addr      = idx_q;
    case (op_q)
      OpSubmit: begin
        wr_addr = task_count_q[IdxW-1:0];
        if (task_count_q >= CntW'(TableDepth)) begin
          res_d = ResFull;
        end else begin
          prio_we      = 1'b1;
          stat_we      = 1'b1;
          stat_wdata   = TsQueued;
          slot_d       = task_count_q[IdxW-1:0];
          task_count_d = task_count_q + CntW'(1);
          queued_d     = queued_q + CntW'(1);
        end
      end
      OpDispatch: begin
        wr_addr = best_idx_q;
        if (limit_hit) begin
          res_d = ResLimit;
        end else if (!found_q) begin
          res_d = ResNone;
        end else begin
          stat_we    = 1'b1;
          stat_wdata = TsRunning;
          slot_d     = best_idx_q;
          running_d  = running_q + CntW'(1);
          if (queued_q != '0) begin
            queued_d = queued_q - CntW'(1);
          end
        end
      end
      OpComplete: begin
        wr_addr = idx_q;
        if ({1'b0, idx_q} >= task_count_q) begin
          res_d = ResBadSlot;
        end else begin
          if ((stat_rd_q == TsQueued) && (queued_q != '0)) begin
            queued_d = queued_q - CntW'(1);
          end
          stat_we    = 1'b1;
          stat_wdata = success_q ? TsDone : TsFailed;
          if (running_q != '0) begin
            running_d = running_q - CntW'(1);
          end
          completed_d = completed_q + CompW'(1);
          slot_d      = idx_q;
        end
      end
      default: res_d = ResOk;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && prio_we) begin
      prio_mem[wr_addr] <= prio_q;
    end
    if (cmd_i.commit && stat_we) begin
      stat_mem[wr_addr] <= stat_wdata;
    end
    if (rd_en) begin
      prio_rd_q  <= prio_mem[rd_addr];
      stat_rd_q  <= stat_mem[rd_addr];
      scan_idx_q <= rd_addr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      prio_q    <= PrioW'(priority_req_i);
      idx_q     <= task_index_i;
      success_q <= success_i;
    end
    best_prio_q <= best_prio_d;
    best_idx_q  <= best_idx_d;
    if (cmd_i.commit) begin
      res_q  <= res_d;
      slot_q <= slot_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_count_q <= '0;
      queued_q     <= '0;
      running_q    <= '0;
      completed_q  <= '0;
      out_valid_q  <= 1'b0;
      found_q      <= 1'b0;
      scan_vld_q   <= 1'b0;
      scan_addr_q  <= '0;
    end else begin
      found_q    <= found_d;
      scan_vld_q <= cmd_i.scan_issue;
      if (cmd_i.scan_clear) begin
        scan_addr_q <= '0;
      end else if (cmd_i.scan_issue) begin
        scan_addr_q <= scan_addr_q + CntW'(1);
      end
      if (cmd_i.commit) begin
        task_count_q <= task_count_d;
        queued_q     <= queued_d;
        running_q    <= running_d;
        completed_q  <= completed_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The counts in the result register are the architectural counters,
  // which only change on a commit that also reloads the result.
  assign out_valid_o       = out_valid_q;
  assign status_o          = res_q;
  assign slot_o            = slot_q;
  assign queued_count_o    = queued_q;
  assign running_count_o   = running_q;
  assign completed_count_o = completed_q;

endmodule

/* rtl/priority_task_dispatcher.sv */
// ----------------------------------------------------------------------------
// priority_task_dispatcher
// Task table with priority dispatch under a programmable concurrency limit.
// ----------------------------------------------------------------------------
// The block keeps a table of up to 64 tasks. A submit transfer appends a
// queued task with a signed priority and returns its slot; a dispatch
// transfer picks the queued task of highest priority (lowest slot on ties),
// marks it running and returns its slot unless the running count has
// reached the run limit; a complete transfer marks a task done or failed.
// Every result carries the queued, running and completed counts. One
// request is worked on at a time. A complete reads the table once before
// its result, and a dispatch that searches walks the submitted tasks
// through the table's single read port, one entry per cycle. A new request
// is taken while the previous result still sits in the output register;
// its result is held back until that register has been emptied. Writes to
// the run limit are taken at any time and are meant for when the block is
// idle; a value of zero acts as the default of four.
// ----------------------------------------------------------------------------
module priority_task_dispatcher import ptd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Configuration write channel.
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [LimitW-1:0]          run_limit_i,
  // Request channel.
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 op_i,
  input  logic signed [ReqPrioW-1:0] priority_req_i,
  input  logic [IdxW-1:0]            task_index_i,
  input  logic                       success_i,
  // Result channel.
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [2:0]                 status_o,
  output logic [IdxW-1:0]            slot_o,
  output logic [CntW-1:0]            queued_count_o,
  output logic [CntW-1:0]            running_count_o,
  output logic [CompW-1:0]           completed_count_o
);

`include "assert_macros.svh"

  cmd_t              cmd;
  sts_t              sts;
  logic [LimitW-1:0] limit_q;
  res_e              res;
  op_e               op;

  // The configuration register can always take a transfer.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= DefaultLimit;
    end else if (cfg_valid_i) begin
      limit_q <= run_limit_i;
    end
  end

  assign op = op_e'(op_i);

  ptd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  ptd_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .limit_i           (limit_q),
    .op_i              (op),
    .priority_req_i    (priority_req_i),
    .task_index_i      (task_index_i),
    .success_i         (success_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .status_o          (res),
    .slot_o            (slot_o),
    .queued_count_o    (queued_count_o),
    .running_count_o   (running_count_o),
    .completed_count_o (completed_count_o)
  );

  assign status_o = res;

  // An error result never names a slot.
  `ASSERT_IMPLY(a_err_slot_zero, clk_i, rst_ni,
                out_valid_o && (status_o != ResOk), slot_o == '0,
                "error result carries a nonzero slot")

  // The block is busy in the cycle after it takes a request.
  `ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni,
               in_valid_i && in_ready_o, !in_ready_o,
               "request channel ready right after a transfer")

  // Neither task count can exceed the table size.
  `ASSERT_IMPLY(a_counts_bounded, clk_i, rst_ni, out_valid_o,
                (queued_count_o <= CntW'(TableDepth))
                && (running_count_o <= CntW'(TableDepth)),
                "task count above table size")

endmodule

/* tb/priority_task_dispatcher_tb.sv */
// ----------------------------------------------------------------------------
// priority_task_dispatcher_tb
// Self-checking testbench for the priority task dispatcher. A scoreboard
// keeps its own copy of the task table and the counters, predicts the result
// of every accepted request and compares each returned result field by field.
// A short directed sequence covers the corner cases, then random traffic runs
// under several concurrency limits with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module priority_task_dispatcher_tb;
  import ptd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The slowest correct request is a searching dispatch over a full table,
  // plus the longest sender gap and the longest receiver stall. About 720
  // requests at that pace still end well inside the limit below, which
  // leaves a wide margin.
  localparam int unsigned CycleLimit   = 500_000;
  localparam int unsigned TailCycles   = 100;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned PhaseCount   = 7;
  localparam int unsigned MaxIdle      = 19;

  // One predicted result of the dispatcher.
  typedef struct {
    res_e              status;
    logic [IdxW-1:0]   slot;
    logic [CntW-1:0]   queued;
    logic [CntW-1:0]   running;
    logic [CompW-1:0]  completed;
  } dispatch_result_t;

  // Scoreboard: a behavioral copy of the task table. Every accepted request
  // is applied to it at once, and the resulting counts are queued until the
  // block returns the matching result.
  class dispatch_scoreboard;
    logic signed [PrioW-1:0] prio_tbl [TableDepth];
    tstat_e                  stat_tbl [TableDepth];
    logic [CntW-1:0]         n_tasks;
    logic [CntW-1:0]         n_queued;
    logic [CntW-1:0]         n_running;
    logic [CompW-1:0]        n_completed;
    logic [LimitW-1:0]       limit;
    dispatch_result_t        predicted_q [$];
    int unsigned             errors;

    function new();
      n_tasks     = '0;
      n_queued    = '0;
      n_running   = '0;
      n_completed = '0;
      limit       = DefaultLimit;
      errors      = 0;
    endfunction

    function void set_limit(logic [LimitW-1:0] value);
      limit = value;
    endfunction

    function int unsigned task_total();
      return n_tasks;
    endfunction

    function int unsigned pending();
      return predicted_q.size();
    endfunction

    // Applies one accepted request and queues the result it must produce.
    function void note_request(op_e op, logic signed [ReqPrioW-1:0] prio,
                               logic [IdxW-1:0] idx, logic ok);
      dispatch_result_t  res;
      logic [LimitW-1:0] cap;
      logic              found;
      int unsigned       best;
      res.status = ResOk;
      res.slot   = '0;
      found      = 1'b0;
      best       = 0;
      case (op)
        OpSubmit: begin
          if (n_tasks >= TableDepth) begin
            res.status = ResFull;
          end else begin
            prio_tbl[n_tasks] = prio;
            stat_tbl[n_tasks] = TsQueued;
            res.slot = n_tasks[IdxW-1:0];
            n_tasks++;
            n_queued++;
          end
        end
        OpDispatch: begin
          cap = (limit == '0) ? DefaultLimit : limit;
          if (n_running >= cap) begin
            res.status = ResLimit;
          end else begin
            // Strict compare keeps the lowest slot among equal priorities.
            for (int i = 0; i < n_tasks; i++) begin
              if (stat_tbl[i] == TsQueued && (!found || prio_tbl[i] > prio_tbl[best])) begin
                best  = i;
                found = 1'b1;
              end
            end
            if (!found) begin
              res.status = ResNone;
            end else begin
              stat_tbl[best] = TsRunning;
              n_running++;
              if (n_queued != '0) n_queued--;
              res.slot = best[IdxW-1:0];
            end
          end
        end
        OpComplete: begin
          if (idx >= n_tasks) begin
            res.status = ResBadSlot;
          end else begin
            // Any submitted slot counts a completion, whatever its state.
            if (stat_tbl[idx] == TsQueued && n_queued != '0) n_queued--;
            stat_tbl[idx] = ok ? TsDone : TsFailed;
            if (n_running != '0) n_running--;
            n_completed++;
            res.slot = idx;
          end
        end
        OpNop: begin
        end
        default: begin
        end
      endcase
      res.queued    = n_queued;
      res.running   = n_running;
      res.completed = n_completed;
      predicted_q.push_back(res);
    endfunction

    function void report_field(string name, longint unsigned want, longint unsigned got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    endfunction

    // Compares one returned result with the oldest prediction.
    function void check_result(logic [2:0] st, logic [IdxW-1:0] sl, logic [CntW-1:0] qc,
                               logic [CntW-1:0] rc, logic [CompW-1:0] cc);
      dispatch_result_t want;
      if (predicted_q.size() == 0) begin
        errors++;
        $display("%0t: result without a pending request, expected none, actual status %0d",
                 $time, st);
        return;
      end
      want = predicted_q.pop_front();
      if (st !== want.status)    report_field("status", want.status, st);
      if (sl !== want.slot)      report_field("slot", want.slot, sl);
      if (qc !== want.queued)    report_field("queued_count", want.queued, qc);
      if (rc !== want.running)   report_field("running_count", want.running, rc);
      if (cc !== want.completed) report_field("completed_count", want.completed, cc);
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [LimitW-1:0]          run_limit_i;
  logic                       in_valid_i;
  logic                       in_ready_o;
  logic [1:0]                 op_i;
  logic signed [ReqPrioW-1:0] priority_req_i;
  logic [IdxW-1:0]            task_index_i;
  logic                       success_i;
  logic                       out_valid_o;
  logic                       out_ready_i;
  logic [2:0]                 status_o;
  logic [IdxW-1:0]            slot_o;
  logic [CntW-1:0]            queued_count_o;
  logic [CntW-1:0]            running_count_o;
  logic [CompW-1:0]           completed_count_o;

  dispatch_scoreboard sb = new();

  // When set, both channels run back to back with no idle cycles.
  bit          no_idle = 1'b0;
  int unsigned cycle_count = 0;

  priority_task_dispatcher uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .run_limit_i       (run_limit_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .priority_req_i    (priority_req_i),
    .task_index_i      (task_index_i),
    .success_i         (success_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_o          (status_o),
    .slot_o            (slot_o),
    .queued_count_o    (queued_count_o),
    .running_count_o   (running_count_o),
    .completed_count_o (completed_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic int unsigned idle_cycles();
    return no_idle ? 0 : $urandom_range(0, MaxIdle);
  endfunction

  // Presents one request and returns in the time step of its transfer. The
  // valid is left high so that a following request with no gap keeps it up
  // without a second assignment in the same step.
  task automatic send_request(input op_e op, input logic signed [ReqPrioW-1:0] prio,
                              input logic [IdxW-1:0] idx, input logic ok);
    int unsigned gap;
    gap = idle_cycles();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    priority_req_i <= prio;
    task_index_i   <= idx;
    success_i      <= ok;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(op, prio, idx, ok);
  endtask

  // Draws one random request. Most completes name a submitted slot, and half
  // of the priorities come from a narrow band so that ties are common.
  task automatic send_random();
    op_e                        op;
    logic signed [ReqPrioW-1:0] prio;
    logic [IdxW-1:0]            idx;
    int unsigned                roll;
    roll = $urandom_range(0, 99);
    if (roll < 12)      op = OpSubmit;
    else if (roll < 47) op = OpDispatch;
    else if (roll < 90) op = OpComplete;
    else                op = OpNop;
    if ($urandom_range(0, 1) == 1) prio = ReqPrioW'($urandom);
    else                           prio = ReqPrioW'($urandom_range(0, 4) - 2);
    if (sb.task_total() > 0 && $urandom_range(0, 99) < 85) begin
      idx = IdxW'($urandom_range(0, sb.task_total() - 1));
    end else begin
      idx = IdxW'($urandom_range(0, TableDepth - 1));
    end
    send_request(op, prio, idx, 1'($urandom_range(0, 1)));
  endtask

  // Stops the sender and waits until every predicted result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // Writes the run limit; only called while the block is idle.
  task automatic write_limit(input logic [LimitW-1:0] value);
    cfg_valid_i <= 1'b1;
    run_limit_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_limit(value);
  endtask

  // Result side: random back-pressure, each transfer checked on the spot.
  initial begin : result_sink
    int unsigned stall;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = idle_cycles();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(status_o, slot_o, queued_count_o, running_count_o, completed_count_o);
    end
  end

  initial begin : stimulus
    logic [LimitW-1:0] phase_limits [PhaseCount];
    cfg_valid_i      = 1'b0;
    run_limit_i      = '0;
    in_valid_i       = 1'b0;
    op_i             = OpNop;
    priority_req_i   = '0;
    task_index_i     = '0;
    success_i        = 1'b0;
    rst_ni           = 1'b0;

    // Zero stands for the default limit, 127 is the top of the register and
    // can never be reached by the running count, 1 and 64 are the ends of the
    // useful range.
    phase_limits[0] = '0;
    phase_limits[1] = LimitW'(1);
    phase_limits[2] = LimitW'(64);
    phase_limits[3] = LimitW'(127);
    phase_limits[4] = LimitW'($urandom_range(2, 8));
    phase_limits[5] = DefaultLimit;
    phase_limits[6] = LimitW'($urandom_range(1, 64));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_limit(phase_limits[0]);

    // Directed part: empty table, bad slots, the no-op code, extreme and tied
    // priorities, early and repeated completes and the running count floor.
    send_request(OpDispatch, 8'sd5, 6'd0, 1'b1);
    send_request(OpComplete, 8'sd0, 6'd0, 1'b1);
    send_request(OpComplete, 8'sd0, 6'd63, 1'b0);
    send_request(OpNop, -8'sd1, 6'd63, 1'b1);
    send_request(OpSubmit, -8'sd128, 6'd0, 1'b0);
    send_request(OpSubmit, 8'sd127, 6'd63, 1'b1);
    send_request(OpSubmit, 8'sd127, 6'd0, 1'b0);
    send_request(OpSubmit, 8'sd0, 6'd0, 1'b0);
    send_request(OpSubmit, -8'sd1, 6'd0, 1'b0);
    // Two dispatches of the tied top priority: the lower slot goes first.
    send_request(OpDispatch, 8'sd0, 6'd0, 1'b0);
    send_request(OpDispatch, 8'sd0, 6'd0, 1'b0);
    // A task completed while still queued leaves the queued count.
    send_request(OpComplete, 8'sd0, 6'd4, 1'b0);
    send_request(OpComplete, 8'sd0, 6'd1, 1'b1);
    // Completing the same slot again still counts, down to zero running.
    send_request(OpComplete, 8'sd0, 6'd1, 1'b1);
    send_request(OpComplete, 8'sd0, 6'd1, 1'b0);
    send_request(OpDispatch, 8'sd0, 6'd0, 1'b0);
    send_request(OpDispatch, 8'sd0, 6'd0, 1'b0);
    send_request(OpDispatch, 8'sd0, 6'd0, 1'b0);
    send_request(OpComplete, 8'sd0, 6'd5, 1'b1);
    send_request(OpNop, -8'sd128, 6'd0, 1'b0);

    // Random part, one phase per limit. The sender pauses at every phase
    // boundary until all results are back, so the register is only written
    // while the block is idle.
    for (int ph = 0; ph < PhaseCount; ph++) begin
      if (ph != 0) begin
        drain_results();
        write_limit(phase_limits[ph]);
      end
      for (int n = 0; n < PhaseItems; n++) begin
        if ($urandom_range(0, 39) == 0) no_idle = ~no_idle;
        send_random();
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk_i);

    if (sb.pending() != 0) begin
      sb.errors++;
      $display("%0t: results missing, expected %0d more, actual 0", $time, sb.pending());
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ptd_pkg.sv
rtl/ptd_ctrl.sv
rtl/ptd_datapath.sv
rtl/priority_task_dispatcher.sv
tb/priority_task_dispatcher_tb.sv
